/* rtl/cdnc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and calendar helpers for the day number converter.
package cdnc_pkg;

  localparam int YEAR_W = 14;
  localparam int CNT_W  = 22;

  localparam logic REQ_TO_COUNT = 1'b0;
  localparam logic REQ_TO_DATE  = 1'b1;

  localparam logic [13:0] WIN_LOW  = 14'd1900;
  localparam logic [13:0] WIN_HIGH = 14'd2099;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [8:0]  DAYS_YEAR = 9'd365;
  localparam logic [8:0]  DAYS_LEAP = 9'd366;
  localparam logic [17:0] DAYS_400Y = 18'd146097;

  // floor(400 * 2^32 / 146097): year estimate is (x * RECIP_Q32) >> 32, low by at most one
  localparam logic [23:0] RECIP_Q32 = 24'(64'd1717986918400 / 64'd146097);
  // floor(x / 25) == (x * 2622) >> 16 for any 12-bit x
  localparam logic [11:0] DIV25_MUL = 12'd2622;

  localparam int D2C_LAT = 3;
  localparam int C2D_LAT = 11;

  typedef struct packed {
    logic              req_type;
    logic [YEAR_W-1:0] in_year;
    logic [3:0]        in_month;
    logic [4:0]        in_day;
    logic [CNT_W-1:0]  in_day_count;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  out_day_count;
    logic [YEAR_W-1:0] out_year;
    logic [3:0]        out_month;
    logic [4:0]        out_day;
    logic              date_in_window;
    logic              request_error;
  } res_t;

  // Terms of the day count at the start of a year, p = year - 1
  typedef struct packed {
    logic [21:0] base365;
    logic [11:0] q4;
    logic [11:0] q100;
    logic [11:0] q400;
  } ys_parts_t;

  function automatic logic [11:0] div25(input logic [11:0] x);
    logic [23:0] prod;
    prod = x * DIV25_MUL;
    return {4'd0, prod[23:16]};
  endfunction

  function automatic ys_parts_t ys_parts(input logic [13:0] p);
    ys_parts_t s;
    s.base365 = {8'd0, p} * 22'd365;
    s.q4      = p[13:2];
    s.q100    = div25(p[13:2]);
    s.q400    = div25({2'd0, p[13:4]});
    return s;
  endfunction

  function automatic logic [21:0] ys_sum(input ys_parts_t s);
    return s.base365 + {10'd0, s.q4} - {10'd0, s.q100} + {10'd0, s.q400};
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB:                  len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s + ((leap && m > MONTH_FEB) ? 9'd1 : 9'd0);
  endfunction

  // Days in the year through the last day of month k
  function automatic logic [8:0] cum_end(input logic [3:0] k, input logic leap);
    logic [8:0] s;
    case (k)
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      4'd12:   s = 9'd365;
      default: s = 9'd0;
    endcase
    return s + ((leap && k > MONTH_JAN) ? 9'd1 : 9'd0);
  endfunction

endpackage

/* rtl/cdnc_d2c.sv */
`timescale 1ns / 1ps
// Three-stage datapath that turns a year, month and day into a day count.
module cdnc_d2c #(
  parameter int unsigned MAX_YEAR  = 9999,
  parameter logic [21:0] MAX_COUNT = 22'd3652058
) (
  input  logic            clk,
  input  cdnc_pkg::req_t  req,
  output cdnc_pkg::res_t  res
);

  localparam logic [13:0] MaxYear = 14'(MAX_YEAR);

  typedef struct packed {
    cdnc_pkg::ys_parts_t parts;
    logic [11:0]         a25;
    logic [13:0]         yc;
    logic                y_zero;
    logic                y_high;
    logic [3:0]          m;
    logic [4:0]          d;
    logic                mon_ok;
    logic                err;
  } s1_t;

  typedef struct packed {
    logic [21:0] ys;
    logic [8:0]  dbm;
    logic [4:0]  d;
    logic        y_zero;
    logic        y_high;
    logic        err;
    logic        win;
  } s2_t;

  s1_t            s1_r, s1_nxt;
  s2_t            s2_r, s2_nxt;
  cdnc_pkg::res_t res_r, res_nxt;

  logic        leap;
  logic [11:0] rem25;
  logic [4:0]  last;
  logic [22:0] sum;

  always_comb begin
    s1_nxt.y_zero = (req.in_year == 14'd0);
    s1_nxt.y_high = (req.in_year > MaxYear);
    s1_nxt.yc     = (s1_nxt.y_zero || s1_nxt.y_high) ? 14'd1 : req.in_year;
    s1_nxt.m      = req.in_month;
    s1_nxt.d      = req.in_day;
    s1_nxt.mon_ok = (req.in_month >= cdnc_pkg::MONTH_JAN) &&
                    (req.in_month <= cdnc_pkg::MONTH_DEC);
    s1_nxt.err    = !s1_nxt.mon_ok || (req.in_day == 5'd0);
    s1_nxt.parts  = cdnc_pkg::ys_parts(s1_nxt.yc - 14'd1);
    s1_nxt.a25    = cdnc_pkg::div25(s1_nxt.yc[13:2]);
  end

  always_comb begin
    rem25 = s1_r.yc[13:2] - s1_r.a25 * 12'd25;
    leap  = (s1_r.yc[1:0] == 2'd0) && ((rem25 != 12'd0) || (s1_r.yc[3:2] == 2'd0));
    last  = cdnc_pkg::month_len(s1_r.m, leap);
    s2_nxt.ys     = cdnc_pkg::ys_sum(s1_r.parts);
    s2_nxt.dbm    = cdnc_pkg::days_before(s1_r.m, leap);
    s2_nxt.d      = s1_r.d;
    s2_nxt.y_zero = s1_r.y_zero;
    s2_nxt.y_high = s1_r.y_high;
    s2_nxt.err    = s1_r.err;
    s2_nxt.win    = (s1_r.yc >= cdnc_pkg::WIN_LOW) && (s1_r.yc <= cdnc_pkg::WIN_HIGH) &&
                    s1_r.mon_ok && (s1_r.d != 5'd0) && (s1_r.d <= last);
  end

  always_comb begin
    sum     = {1'b0, s2_r.ys} + {14'd0, s2_r.dbm} + {18'd0, s2_r.d} - 23'd1;
    res_nxt = '0;
    if (s2_r.err) begin
      res_nxt.request_error = 1'b1;
    end else begin
      if (s2_r.y_zero) begin
        res_nxt.out_day_count = '0;
      end else if (s2_r.y_high || (sum > {1'b0, MAX_COUNT})) begin
        res_nxt.out_day_count = MAX_COUNT;
      end else begin
        res_nxt.out_day_count = sum[21:0];
      end
      res_nxt.date_in_window = s2_r.win;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

/* rtl/cdnc_c2d.sv */
`timescale 1ns / 1ps
// Eleven-stage datapath that turns a day count into a year, month and day.
module cdnc_c2d #(
  parameter logic [21:0] MAX_COUNT = 22'd3652058
) (
  input  logic            clk,
  input  cdnc_pkg::req_t  req,
  output cdnc_pkg::res_t  res
);

  logic [21:0] nc1_r, nc1_nxt, x1_r, x1_nxt;
  logic [21:0] nc2_r, x2_r;
  logic [13:0] qe2_r, qe2_nxt;
  logic [45:0] prod2;
  logic [21:0] nc3_r, x3_r;
  logic [13:0] qe3_r;
  logic [31:0] pr3_r, pr3_nxt;
  logic [21:0] nc4_r;
  logic [13:0] qe4_r;
  logic [31:0] r4_r, r4_nxt, xw, x400;
  logic [21:0] nc5_r;
  logic [13:0] oy5_r, oy5_nxt, oy_est;
  logic [21:0] nc6_r;
  logic [13:0] oy6_r;
  cdnc_pkg::ys_parts_t parts6_r [4];
  cdnc_pkg::ys_parts_t parts6_nxt [4];
  logic [21:0] nc7_r;
  logic [13:0] oy7_r;
  logic [21:0] ys7_r [4];
  logic [21:0] ys7_nxt [4];
  logic [21:0] nc8_r, ysel8_r, ysel8_nxt, ynext8_r, ynext8_nxt;
  logic [13:0] oy8_r, oy8_nxt;
  logic        dec8, inc8;
  logic [13:0] oy9_r;
  logic [22:0] doy9_r, doy9_nxt;
  logic        leap9_r, leap9_nxt;
  logic [13:0] oy10_r;
  logic [22:0] doy10_r;
  logic        leap10_r;
  logic [3:0]  om10_r, om10_nxt;
  logic [8:0]  base10_r, base10_nxt;
  logic        found;
  logic [22:0] odw;
  logic [4:0]  last;
  cdnc_pkg::res_t res_r, res_nxt;

  always_comb begin
    nc1_nxt = (req.in_day_count > MAX_COUNT) ? MAX_COUNT : req.in_day_count;
    x1_nxt  = nc1_nxt + 22'd365;
  end

  always_comb begin
    prod2   = 46'(x1_r) * 46'(cdnc_pkg::RECIP_Q32);
    qe2_nxt = prod2[45:32];
  end

  assign pr3_nxt = {18'd0, qe2_r} * 32'(cdnc_pkg::DAYS_400Y);

  always_comb begin
    xw     = {10'd0, x3_r};
    x400   = (xw << 8) + (xw << 7) + (xw << 4);
    r4_nxt = x400 - pr3_r;
  end

  always_comb begin
    oy_est  = qe4_r + ((r4_r >= 32'(cdnc_pkg::DAYS_400Y)) ? 14'd1 : 14'd0);
    oy5_nxt = (oy_est == 14'd0) ? 14'd1 : oy_est;
  end

  // Candidate years oy-1 .. oy+2 start at p = oy-2 .. oy+1
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i == 0 && oy5_r < 14'd2) begin
        parts6_nxt[i] = cdnc_pkg::ys_parts(14'd0);
      end else begin
        parts6_nxt[i] = cdnc_pkg::ys_parts(oy5_r + 14'(i) - 14'd2);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ys7_nxt[i] = cdnc_pkg::ys_sum(parts6_r[i]);
    end
  end

  always_comb begin
    dec8 = (oy7_r > 14'd1) && (nc7_r < ys7_r[1]);
    inc8 = nc7_r >= ys7_r[2];
    if (dec8) begin
      oy8_nxt    = oy7_r - 14'd1;
      ysel8_nxt  = ys7_r[0];
      ynext8_nxt = ys7_r[1];
    end else if (inc8) begin
      oy8_nxt    = oy7_r + 14'd1;
      ysel8_nxt  = ys7_r[2];
      ynext8_nxt = ys7_r[3];
    end else begin
      oy8_nxt    = oy7_r;
      ysel8_nxt  = ys7_r[1];
      ynext8_nxt = ys7_r[2];
    end
  end

  always_comb begin
    doy9_nxt  = {1'b0, nc8_r} - {1'b0, ysel8_r};
    leap9_nxt = (ynext8_r - ysel8_r) == 22'(cdnc_pkg::DAYS_LEAP);
  end

  // First month whose end lies past the day of year; a count past the year stays in December
  always_comb begin
    om10_nxt = cdnc_pkg::MONTH_DEC;
    found    = 1'b0;
    for (int k = 12; k >= 1; k--) begin
      if (!doy9_r[22] && (doy9_r[21:0] < {13'd0, cdnc_pkg::cum_end(4'(k), leap9_r)})) begin
        om10_nxt = 4'(k);
        found    = 1'b1;
      end
    end
    if (found) begin
      base10_nxt = cdnc_pkg::days_before(om10_nxt, leap9_r);
    end else begin
      base10_nxt = leap9_r ? cdnc_pkg::DAYS_LEAP : cdnc_pkg::DAYS_YEAR;
    end
  end

  always_comb begin
    odw     = doy10_r - {14'd0, base10_r} + 23'd1;
    last    = cdnc_pkg::month_len(om10_r, leap10_r);
    res_nxt = '0;
    res_nxt.out_year       = oy10_r;
    res_nxt.out_month      = om10_r;
    res_nxt.out_day        = odw[4:0];
    res_nxt.date_in_window = (oy10_r >= cdnc_pkg::WIN_LOW) && (oy10_r <= cdnc_pkg::WIN_HIGH) &&
                             !doy10_r[22] && (odw != 23'd0) && (odw <= {18'd0, last});
  end

  always_ff @(posedge clk) begin
    nc1_r    <= nc1_nxt;
    x1_r     <= x1_nxt;
    nc2_r    <= nc1_r;
    x2_r     <= x1_r;
    qe2_r    <= qe2_nxt;
    nc3_r    <= nc2_r;
    x3_r     <= x2_r;
    qe3_r    <= qe2_r;
    pr3_r    <= pr3_nxt;
    nc4_r    <= nc3_r;
    qe4_r    <= qe3_r;
    r4_r     <= r4_nxt;
    nc5_r    <= nc4_r;
    oy5_r    <= oy5_nxt;
    nc6_r    <= nc5_r;
    oy6_r    <= oy5_r;
    parts6_r <= parts6_nxt;
    nc7_r    <= nc6_r;
    oy7_r    <= oy6_r;
    ys7_r    <= ys7_nxt;
    nc8_r    <= nc7_r;
    oy8_r    <= oy8_nxt;
    ysel8_r  <= ysel8_nxt;
    ynext8_r <= ynext8_nxt;
    oy9_r    <= oy8_r;
    doy9_r   <= doy9_nxt;
    leap9_r  <= leap9_nxt;
    oy10_r   <= oy9_r;
    doy10_r  <= doy9_r;
    leap10_r <= leap9_r;
    om10_r   <= om10_nxt;
    base10_r <= base10_nxt;
    res_r    <= res_nxt;
  end

  assign res = res_r;

endmodule

/* rtl/calendar_day_number_converter_unit.sv */
`timescale 1ns / 1ps
// A request taken at one edge passes the input register, eleven day-count-to-date stages and
// the output register, and its result shows with out_valid, held for one cycle; the date path
// is padded to match. Throughput: one request every cycle while busy is low.
// Reset (synchronous, rst_n low) clears the valid pipeline; busy is high during reset
// and drops at the first clock edge after it, then stays low, since the receiver cannot stall.
module calendar_day_number_converter_unit #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  cdnc_pkg::req_t  in_req,
  output logic            out_valid,
  output cdnc_pkg::res_t  out_res
);

  localparam int unsigned MyPrev  = MAX_YEAR - 1;
  localparam int unsigned MaxLeap =
    ((((MAX_YEAR % 4) == 0) && ((MAX_YEAR % 100) != 0)) || ((MAX_YEAR % 400) == 0)) ? 1 : 0;
  localparam logic [21:0] MaxCount =
    22'(MyPrev * 365 + MyPrev / 4 - MyPrev / 100 + MyPrev / 400 + 334 + MaxLeap + 30);
  localparam int Lat      = cdnc_pkg::C2D_LAT;
  localparam int Dly      = cdnc_pkg::C2D_LAT - cdnc_pkg::D2C_LAT;
  localparam int TotalLat = cdnc_pkg::C2D_LAT + 2;

  logic              busy_r;
  logic              acc;
  logic [Lat:0]      vld_r;
  logic [Lat:0]      typ_r;
  cdnc_pkg::req_t    req_r;
  cdnc_pkg::res_t    d2c_res;
  cdnc_pkg::res_t    c2d_res;
  cdnc_pkg::res_t    dly_r [Dly];
  logic              out_valid_r;
  cdnc_pkg::res_t    out_res_r, out_res_nxt;

  assign acc = start && !busy_r;

  cdnc_d2c #(
    .MAX_YEAR  (MAX_YEAR),
    .MAX_COUNT (MaxCount)
  ) u_d2c (
    .clk (clk),
    .req (req_r),
    .res (d2c_res)
  );

  cdnc_c2d #(
    .MAX_COUNT (MaxCount)
  ) u_c2d (
    .clk (clk),
    .req (req_r),
    .res (c2d_res)
  );

  assign out_res_nxt = (typ_r[Lat] == cdnc_pkg::REQ_TO_DATE) ? c2d_res : dly_r[Dly-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      vld_r       <= {vld_r[Lat-1:0], acc};
      out_valid_r <= vld_r[Lat];
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= in_req;
    typ_r     <= {typ_r[Lat-1:0], in_req.req_type};
    dly_r[0]  <= d2c_res;
    for (int i = 1; i < Dly; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
    out_res_r <= out_res_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##TotalLat out_valid)
    else $error("request did not produce a result at the expected latency");

  a_err_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.request_error |->
      (out_res.out_day_count == '0) && !out_res.date_in_window && (out_res.out_year == '0))
    else $error("errored request carries a count or window flag");

  a_date_no_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.out_month != 4'd0) |->
      (out_res.out_day_count == '0) && !out_res.request_error && (out_res.out_year != '0))
    else $error("date result mixes in count fields");

  a_window_year : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.date_in_window && (out_res.out_month != 4'd0) |->
      (out_res.out_year >= cdnc_pkg::WIN_LOW) && (out_res.out_year <= cdnc_pkg::WIN_HIGH))
    else $error("window flag set for a year outside the window");

endmodule
